@@ src/mpq_pkg.sv @@
// Shared types, request and status codes for the max-priority queue.
// No dependencies; every other file refers to it by scoped names.
package mpq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int PRI_W        = 16;
  localparam int OCC_W        = 5;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_PEEK   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]                req_type;
    logic signed [VALUE_W-1:0] item_value;
    logic [PRI_W-1:0]          item_priority;
  } req_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] found_value;
    logic [PRI_W-1:0]          found_priority;
    logic [OCC_W-1:0]          occupancy;
  } rsp_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch the accepted request beat
    logic execute;  // apply it to the cells and load the result register
  } cmd_t;

endpackage

@@ src/mpq_ctrl.sv @@
// Controller for the max-priority queue: request/result handshake sequencing.
// Depends on mpq_pkg; drives mpq_dp through mpq_pkg::cmd_t.
module mpq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output mpq_pkg::cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic rsp_valid_next;
  logic advance;

  assign req_stall   = (state != S_IDLE);
  assign cmd.capture = req_valid && (state == S_IDLE);
  // Execute only when the result register is free or being drained
  assign advance     = (state == S_EXEC) && (!rsp_valid || !rsp_stall);
  assign cmd.execute = advance;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.capture) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (advance) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (advance) rsp_valid_next = 1'b1;
    else if (!rsp_stall) rsp_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

@@ src/mpq_dp.sv @@
// Datapath for the max-priority queue: sorted cell chain, count, result register.
// Depends on mpq_pkg; sequenced by mpq_ctrl.
module mpq_dp #(
  parameter int CAPACITY = mpq_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  mpq_pkg::cmd_t cmd,
  input  mpq_pkg::req_t req,
  output mpq_pkg::rsp_t rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  mpq_pkg::req_t req_q;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic signed [mpq_pkg::VALUE_W-1:0] cell_value [CAPACITY];
  logic [mpq_pkg::PRI_W-1:0]          cell_pri   [CAPACITY];
  logic [CAPACITY-1:0]                lt;  // cell is unused or ranks below the new item

  logic full;
  logic empty;
  logic do_ins;
  logic do_rem;
  mpq_pkg::rsp_t rsp_next;

  assign full  = (count == CNT_W'(CAPACITY));
  assign empty = (count == '0);

  always_comb begin
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    count_next = count;
    rsp_next = '0;
    case (req_q.req_type)
      mpq_pkg::REQ_INSERT: begin
        if (full) begin
          rsp_next.status = mpq_pkg::ST_FULL;
        end else begin
          do_ins     = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      mpq_pkg::REQ_REMOVE: begin
        if (empty) begin
          rsp_next.status = mpq_pkg::ST_EMPTY;
        end else begin
          do_rem                  = 1'b1;
          count_next              = count - CNT_W'(1);
          rsp_next.found_value    = cell_value[0];
          rsp_next.found_priority = cell_pri[0];
        end
      end
      default: begin
        // peek, and the unused code which behaves as a peek
        if (empty) begin
          rsp_next.status = mpq_pkg::ST_EMPTY;
        end else begin
          rsp_next.found_value    = cell_value[0];
          rsp_next.found_priority = cell_pri[0];
        end
      end
    endcase
    rsp_next.occupancy = mpq_pkg::OCC_W'(count_next);
  end

  // Head cell holds the highest priority; ties keep arrival order
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign lt[i] = (CNT_W'(i) >= count) || (cell_pri[i] < req_q.item_priority);

    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (cmd.execute) begin
          if (do_ins && lt[0]) begin
            cell_value[0] <= req_q.item_value;
            cell_pri[0]   <= req_q.item_priority;
          end else if (do_rem) begin
            if (CAPACITY > 1) begin
              cell_value[0] <= cell_value[(CAPACITY > 1) ? 1 : 0];
              cell_pri[0]   <= cell_pri[(CAPACITY > 1) ? 1 : 0];
            end
          end
        end
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (cmd.execute) begin
          if (do_ins) begin
            if (lt[i-1]) begin
              cell_value[i] <= cell_value[i-1];
              cell_pri[i]   <= cell_pri[i-1];
            end else if (lt[i]) begin
              cell_value[i] <= req_q.item_value;
              cell_pri[i]   <= req_q.item_priority;
            end
          end else if (do_rem && (i < CAPACITY - 1)) begin
            cell_value[i] <= cell_value[(i < CAPACITY - 1) ? i + 1 : i];
            cell_pri[i]   <= cell_pri[(i < CAPACITY - 1) ? i + 1 : i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.execute) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) req_q <= req;
    if (cmd.execute) rsp <= rsp_next;
  end

endmodule

@@ src/max_priority_queue_top.sv @@
// Top level of the bounded max-priority queue.
// Depends on mpq_pkg, mpq_ctrl and mpq_dp.
//
// Usage:
//   Request channel (req_valid / req_stall / req) carries one beat per
//   request: insert an element with a priority, remove the highest-priority
//   entry, or peek at it. Result channel (rsp_valid / rsp_stall / rsp)
//   returns exactly one beat per request: status, element and priority found
//   (zero unless a remove or peek succeeded) and the occupancy afterwards.
//   Entries live in a chain of CAPACITY cells kept sorted by priority, with
//   equal priorities in arrival order, so the head cell is always the answer
//   and an insert is one compare per cell plus a one-place shift; a remove is a shift.
// Timing:
//   A request beat accepted at one edge is latched, then applied once the
//   result register is free or draining, and its result is offered from then
//   on. One request is held at a time, so no new request is taken until the
//   last is applied, independent of occupancy; the two controller states do this.
// Reset (rst, synchronous): empties the queue and drops any pending result.
// Stall: while rsp_stall holds a result, the next request may be accepted
//   and latched, but it is not applied until the result register frees.
module max_priority_queue_top #(
  parameter int CAPACITY = mpq_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  mpq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output mpq_pkg::rsp_t rsp
);

  mpq_pkg::cmd_t cmd;

  // Sequence handshakes and tell the datapath when to latch and execute
  mpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  // Hold the sorted cells, the entry count and the result register
  mpq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule

@@ src/mpq_checker.sv @@
// Port-level checks for the max-priority queue, bound to the top level.
// Depends on mpq_pkg and max_priority_queue_top.
module mpq_assertions (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input mpq_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input mpq_pkg::rsp_t rsp
);

  // A held result beat stays unchanged
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result beat changed while stalled");

  // Only one request is in work: acceptance closes the request side
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted while one is in work");

  // Reset drops any pending result
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result offered right after reset");

  // An empty error reports nothing found and no entries
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == mpq_pkg::ST_EMPTY |->
      rsp.found_value == '0 && rsp.found_priority == '0 && rsp.occupancy == '0)
    else $error("empty status with data or entries");

  // A full error reports nothing found
  a_full_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == mpq_pkg::ST_FULL |->
      rsp.found_value == '0 && rsp.found_priority == '0)
    else $error("full status with data");

endmodule

bind max_priority_queue_top mpq_assertions u_mpq_assertions (.*);

@@ dv/mpq_checker.sv @@
// Checker for the max-priority queue: watches both channels, predicts every
// result from its own copy of the entries and compares it with the beat seen.
// Depends on mpq_pkg for the beat types and the request and status codes.
module mpq_checker #(
  parameter int CAPACITY = mpq_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  mpq_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  mpq_pkg::rsp_t rsp,
  output int            fail_count,
  output int            pending
);

  logic signed [mpq_pkg::VALUE_W-1:0] held_value    [CAPACITY];
  logic [mpq_pkg::PRI_W-1:0]          held_priority [CAPACITY];
  int                                 held_count;

  mpq_pkg::rsp_t expected_rsp [$];

  initial fail_count = 0;
  initial pending    = 0;

  task automatic report(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  // Apply one request to the predicted queue and return the result it gives.
  function automatic mpq_pkg::rsp_t queue_apply(input mpq_pkg::req_t r);
    mpq_pkg::rsp_t res;
    int            best;
    res = '0;
    res.status = mpq_pkg::ST_OK;
    if (r.req_type == mpq_pkg::REQ_INSERT) begin
      if (held_count >= CAPACITY) begin
        res.status = mpq_pkg::ST_FULL;
      end else begin
        held_value[held_count]    = r.item_value;
        held_priority[held_count] = r.item_priority;
        held_count++;
      end
    end else if (held_count == 0) begin
      res.status = mpq_pkg::ST_EMPTY;
    end else begin
      // first entry with the largest priority: oldest wins a tie
      best = 0;
      for (int i = 1; i < held_count; i++) begin
        if (held_priority[i] > held_priority[best]) best = i;
      end
      res.found_value    = held_value[best];
      res.found_priority = held_priority[best];
      if (r.req_type == mpq_pkg::REQ_REMOVE) begin
        for (int i = best; i + 1 < held_count; i++) begin
          held_value[i]    = held_value[i+1];
          held_priority[i] = held_priority[i+1];
        end
        held_count--;
      end
    end
    res.occupancy = mpq_pkg::OCC_W'(held_count);
    return res;
  endfunction

  always @(posedge clk) begin
    mpq_pkg::rsp_t want;
    if (rst) begin
      held_count = 0;
      expected_rsp.delete();
      pending <= 0;
    end else begin
      // results first: a result never belongs to a request taken at this edge
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          report($sformatf("result beat with nothing expected (status %0d)", rsp.status));
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.status !== want.status)
            report($sformatf("status got %0d expected %0d", rsp.status, want.status));
          if (rsp.found_value !== want.found_value)
            report($sformatf("found_value got %08h expected %08h",
                             rsp.found_value, want.found_value));
          if (rsp.found_priority !== want.found_priority)
            report($sformatf("found_priority got %04h expected %04h",
                             rsp.found_priority, want.found_priority));
          if (rsp.occupancy !== want.occupancy)
            report($sformatf("occupancy got %0d expected %0d",
                             rsp.occupancy, want.occupancy));
        end
      end
      if (req_valid && !req_stall) expected_rsp.push_back(queue_apply(req));
      pending <= expected_rsp.size();
    end
  end

endmodule

@@ dv/max_priority_queue_top_tb.sv @@
// Testbench top for the max-priority queue: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on mpq_pkg, mpq_checker and
// the block under test, max_priority_queue_top.
module max_priority_queue_top_tb;

  // Spare request code, served as a peek
  localparam logic [1:0] REQ_SPARE = 2'd3;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          rsp_stall = 1'b0;
  mpq_pkg::req_t req       = '0;
  logic          req_stall;
  logic          rsp_valid;
  mpq_pkg::rsp_t rsp;

  int fail_count;
  int pending;

  // Hold both sides free of idling while set; the stimulus opens one long
  // stretch of this in the middle of the random part.
  logic calm = 1'b0;

  always #1 clk = ~clk;

  max_priority_queue_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  mpq_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Stall the result channel about a third of the time, changing only on
  // the falling edge so the block sees a settled value at each rising edge.
  always @(negedge clk) begin
    rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 34);
  end

  // Offer one request beat and hold it until the block takes it. Before the
  // beat, drop valid for a random number of cycles unless calm is set.
  task automatic send_request(input logic [1:0] op, input logic [31:0] value,
                              input logic [15:0] pri);
    while (!calm && $urandom_range(99) < 34) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req       <= '{req_type: op, item_value: value, item_priority: pri};
    // req_stall read here is its value before this edge's updates
    do @(posedge clk); while (req_stall);
  endtask

  // Pick a priority: mostly a narrow band so ties are common, with the
  // full range and both extremes mixed in.
  function automatic logic [15:0] pick_priority();
    logic [15:0] p;
    case ($urandom_range(3))
      0:       p = 16'($urandom_range(3));
      1:       p = 16'($urandom);
      2:       p = $urandom_range(1) ? 16'hffff : 16'h0000;
      default: p = 16'($urandom_range(15));
    endcase
    return p;
  endfunction

  initial begin
    int          fill_bias;
    int          roll;
    logic [1:0]  op;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. Empty queue first: peek, remove and the spare request
    // code, which acts as a peek, must all report empty.
    send_request(mpq_pkg::REQ_PEEK,   32'h1234_5678, 16'h00aa);
    send_request(mpq_pkg::REQ_REMOVE, 32'hffff_ffff, 16'hffff);
    send_request(REQ_SPARE,           32'h0000_0000, 16'h0000);

    // Fill to capacity with extreme values and priorities, including ties
    // at the top priority so the older entry must win.
    send_request(mpq_pkg::REQ_INSERT, 32'h7fff_ffff, 16'h0000);
    send_request(mpq_pkg::REQ_INSERT, 32'h8000_0000, 16'hffff);
    send_request(mpq_pkg::REQ_INSERT, 32'h0000_0000, 16'h0005);
    send_request(mpq_pkg::REQ_INSERT, 32'hffff_ffff, 16'h0005);
    send_request(mpq_pkg::REQ_INSERT, 32'h5555_aaaa, 16'hffff);
    for (int i = 0; i < mpq_pkg::CAPACITY_DEF - 5; i++)
      send_request(mpq_pkg::REQ_INSERT, $urandom, 16'(5 + i % 3));

    // Full queue: an insert must be refused and leave the entries alone.
    send_request(mpq_pkg::REQ_INSERT, 32'hdead_beef, 16'hffff);
    send_request(mpq_pkg::REQ_PEEK,   32'h0,         16'h0);
    send_request(REQ_SPARE,           32'hffff_ffff, 16'hffff);
    repeat (3) send_request(mpq_pkg::REQ_REMOVE, $urandom, 16'($urandom));

    // Random part. Drift between filling, draining and balanced phases so
    // the queue often runs full and empty; values take every bit pattern.
    fill_bias = 50;
    for (int n = 0; n < 700; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(2))
          0:       fill_bias = 85;
          1:       fill_bias = 15;
          default: fill_bias = 50;
        endcase
      end
      calm = (n >= 300 && n < 420);
      if ($urandom_range(99) < fill_bias) begin
        op = mpq_pkg::REQ_INSERT;
      end else begin
        roll = $urandom_range(99);
        op = (roll < 70) ? mpq_pkg::REQ_REMOVE : (roll < 95) ? mpq_pkg::REQ_PEEK : REQ_SPARE;
      end
      send_request(op, $urandom, pick_priority());
    end
    calm = 1'b0;

    // Drain: drop valid, wait for every expected result, then a few more
    // cycles so any stray beat is still caught.
    @(negedge clk);
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Guard against a hung handshake: far beyond the slowest correct run.
  initial begin
    #400000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
